### rtl/core/tvht_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the trigger volume hit test.
package tvht_pkg;

    // One trigger record.
    typedef struct packed {
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] base_z;
        logic signed [15:0] axis_a;
        logic signed [15:0] axis_b;
        logic signed [15:0] axis_c;
        logic [30:0]        span_length;
        logic [30:0]        span_height;
        logic [15:0]        kind;
        logic [5:0]         block_flags;
        logic               has_target;
    } t_item;

    // One hit-test result.
    typedef struct packed {
        logic fire;
        logic gated;
    } t_result;

    // Control flags that ride the pipeline with each record.
    typedef struct packed {
        logic blk;     // suppressed by block flags
        logic go;      // not suppressed and has a target
        logic plane;   // plane-crossing kind
        logic hgt;     // actor inside the height band
    } t_ctl;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ACTOR_X    = 3'd0;
    localparam logic [2:0] REG_ACTOR_Y    = 3'd1;
    localparam logic [2:0] REG_ACTOR_Z    = 3'd2;
    localparam logic [2:0] REG_MOTION_X   = 3'd3;
    localparam logic [2:0] REG_MOTION_Y   = 3'd4;
    localparam logic [2:0] REG_MOTION_Z   = 3'd5;
    localparam logic [2:0] REG_SPEED      = 3'd6;
    localparam logic [2:0] REG_ACTOR_MODE = 3'd7;

    localparam logic [2:0] ACTOR_MODE_RESET = 3'd3;

    // Play modes.
    localparam logic [1:0] PMODE_0 = 2'd0;
    localparam logic [1:0] PMODE_1 = 2'd1;
    localparam logic [1:0] PMODE_2 = 2'd2;

    // Position of the nearest point on the segment.
    localparam logic [1:0] REGION_FAR  = 2'd0;
    localparam logic [1:0] REGION_IN   = 2'd1;
    localparam logic [1:0] REGION_NEAR = 2'd2;

    localparam logic [30:0] SPEED_MIN    = 31'd9830400;  // 150.0 in Q16.16
    localparam logic [15:0] KIND_GATE_A  = 16'h0066;
    localparam logic [15:0] KIND_GATE_B  = 16'h0068;
    localparam logic [15:0] MIN_LENGTH_SQ = 16'd1;
    localparam logic [93:0] LQ_LIM = 94'(MIN_LENGTH_SQ) << 60;

    // Squaring unit geometry.
    localparam int MAG_W     = 49;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SQ_LO_W   = 25;
    localparam int SQ_HI_W   = MAG_W - SQ_LO_W;

endpackage

### rtl/core/tvht_sq.sv
`timescale 1ns / 1ps
// Two-stage squarer for a 49-bit magnitude, split into 24-bit high and 25-bit low halves.
module tvht_sq (
    input  logic                       i_clk,
    input  logic [tvht_pkg::MAG_W-1:0] i_x,
    output logic [tvht_pkg::SQ_W-1:0]  o_sq
);

    logic [tvht_pkg::SQ_HI_W-1:0]                  w_hi;
    logic [tvht_pkg::SQ_LO_W-1:0]                  w_lo;
    logic [2*tvht_pkg::SQ_HI_W-1:0]                r_hh;
    logic [tvht_pkg::SQ_HI_W+tvht_pkg::SQ_LO_W-1:0] r_hl;
    logic [2*tvht_pkg::SQ_LO_W-1:0]                r_ll;
    logic [tvht_pkg::SQ_W-1:0]                     r_sq;

    assign w_hi = i_x[tvht_pkg::MAG_W-1:tvht_pkg::SQ_LO_W];
    assign w_lo = i_x[tvht_pkg::SQ_LO_W-1:0];

    always_ff @(posedge i_clk) begin
        r_hh <= w_hi * w_hi;
        r_hl <= w_hi * w_lo;
        r_ll <= w_lo * w_lo;
    end

    // x^2 = hh*2^(2L) + 2*hl*2^L + ll
    always_ff @(posedge i_clk) begin
        r_sq <= (tvht_pkg::SQ_W'(r_hh) << (2 * tvht_pkg::SQ_LO_W))
              + (tvht_pkg::SQ_W'(r_hl) << (tvht_pkg::SQ_LO_W + 1))
              + tvht_pkg::SQ_W'(r_ll);
    end

    assign o_sq = r_sq;

endmodule

### rtl/core/trigger_volume_hit_test_unit.sv
`timescale 1ns / 1ps
// Top level of the trigger volume hit test pipeline.
//
// Usage:
//   Load the actor state (position, motion, speed, mode) through the APB port
//   while no transaction is in flight; registers sit at byte address 4*index.
//   Present one trigger record on i_item with start high; it is taken at the
//   rising edge where start is high and busy is low. busy never rises, so a
//   new record may be issued on every cycle.
//   Each record gives one result: o_done pulses for exactly one cycle with
//   o_result, and the result is taken at the edge that ends that cycle. The
//   receiver cannot stall, so results always leave in issue order.
// Throughput:
//   one record per cycle. The pipeline depth is set by the chain of wide
//   products: difference, cross products, sums, region and magnitudes,
//   split 49-bit squares (two stages), then the final sum and compares.
// Reset:
//   Synchronous, active low. Clears all in-flight valid bits and returns the
//   configuration to zero, with actor_mode at 3 (no play mode).
module trigger_volume_hit_test_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Command channel
    input  logic              start,
    output logic              busy,
    input  tvht_pkg::t_item   i_item,
    // Result channel
    output logic              o_done,
    output tvht_pkg::t_result o_result,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------------------------------------------------------
    // Magnitude of a signed 50-bit value known to be below 2^49.
    // ---------------------------------------------------------------
    function automatic logic [tvht_pkg::MAG_W-1:0] f_mag(
        input logic signed [tvht_pkg::MAG_W:0] v
    );
        logic [tvht_pkg::MAG_W:0] t;
        t = v[tvht_pkg::MAG_W] ? -v : v;
        return t[tvht_pkg::MAG_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [31:0] r_actor_x, r_actor_y, r_actor_z;
    logic signed [31:0] r_motion_x, r_motion_y, r_motion_z;
    logic [30:0]        r_actor_speed;
    logic [2:0]         r_actor_mode;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_actor_x     <= '0;
            r_actor_y     <= '0;
            r_actor_z     <= '0;
            r_motion_x    <= '0;
            r_motion_y    <= '0;
            r_motion_z    <= '0;
            r_actor_speed <= '0;
            r_actor_mode  <= tvht_pkg::ACTOR_MODE_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                tvht_pkg::REG_ACTOR_X:    r_actor_x     <= pwdata;
                tvht_pkg::REG_ACTOR_Y:    r_actor_y     <= pwdata;
                tvht_pkg::REG_ACTOR_Z:    r_actor_z     <= pwdata;
                tvht_pkg::REG_MOTION_X:   r_motion_x    <= pwdata;
                tvht_pkg::REG_MOTION_Y:   r_motion_y    <= pwdata;
                tvht_pkg::REG_MOTION_Z:   r_motion_z    <= pwdata;
                tvht_pkg::REG_SPEED:      r_actor_speed <= pwdata[30:0];
                tvht_pkg::REG_ACTOR_MODE: r_actor_mode  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            tvht_pkg::REG_ACTOR_X:    prdata = r_actor_x;
            tvht_pkg::REG_ACTOR_Y:    prdata = r_actor_y;
            tvht_pkg::REG_ACTOR_Z:    prdata = r_actor_z;
            tvht_pkg::REG_MOTION_X:   prdata = r_motion_x;
            tvht_pkg::REG_MOTION_Y:   prdata = r_motion_y;
            tvht_pkg::REG_MOTION_Z:   prdata = r_motion_z;
            tvht_pkg::REG_SPEED:      prdata = {1'b0, r_actor_speed};
            tvht_pkg::REG_ACTOR_MODE: prdata = {29'b0, r_actor_mode};
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Stage 1: gating, offsets, height band, L^2 and a^2+b^2
    // ---------------------------------------------------------------
    logic               w_acc;
    logic [5:0]         w_f;
    logic [1:0]         w_pmode;
    logic               w_blk;
    logic signed [34:0] w_oz2, w_ztop, w_zbot;
    logic signed [31:0] w_aa, w_bb;
    tvht_pkg::t_ctl     n1_ctl;

    assign w_acc   = start && !busy;
    assign w_f     = i_item.block_flags;
    assign w_pmode = r_actor_mode[1:0];

    // bit0 always, bit1 slow, bits2-4 per play mode, bit5 status clear
    assign w_blk = (w_f != 6'd0) && (w_f[0]
                 || (w_f[1] && (r_actor_speed < tvht_pkg::SPEED_MIN))
                 || (!r_actor_mode[2] && w_f[5])
                 || ((w_pmode == tvht_pkg::PMODE_0) && w_f[2])
                 || ((w_pmode == tvht_pkg::PMODE_1) && w_f[3])
                 || ((w_pmode == tvht_pkg::PMODE_2) && w_f[4]));

    // Compare at twice the scale so H/2 stays exact.
    assign w_oz2  = $signed({{2{r_actor_z[31]}}, r_actor_z, 1'b0});
    assign w_ztop = $signed({{2{i_item.base_z[31]}}, i_item.base_z, 1'b0})
                  + $signed({4'b0, i_item.span_height});
    assign w_zbot = $signed({{2{i_item.base_z[31]}}, i_item.base_z, 1'b0})
                  - $signed({4'b0, i_item.span_height});

    assign w_aa = i_item.axis_a * i_item.axis_a;
    assign w_bb = i_item.axis_b * i_item.axis_b;

    always_comb begin
        n1_ctl.blk   = w_blk;
        n1_ctl.go    = !w_blk && i_item.has_target;
        n1_ctl.plane = (i_item.kind == tvht_pkg::KIND_GATE_A)
                    || (i_item.kind == tvht_pkg::KIND_GATE_B);
        n1_ctl.hgt   = (w_oz2 < w_ztop) && (w_zbot < w_oz2);
    end

    logic                r1_v;
    tvht_pkg::t_ctl      r1_ctl;
    logic signed [32:0]  r1_dx, r1_dy;
    logic signed [15:0]  r1_a, r1_b, r1_c;
    logic signed [31:0]  r1_bx, r1_by, r1_bz;
    logic [30:0]         r1_len;
    logic [61:0]         r1_ll;
    logic [31:0]         r1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= w_acc;
    end

    always_ff @(posedge i_clk) begin
        r1_ctl <= n1_ctl;
        r1_dx  <= 33'(r_actor_x) - 33'(i_item.base_x);
        r1_dy  <= 33'(r_actor_y) - 33'(i_item.base_y);
        r1_a   <= i_item.axis_a;
        r1_b   <= i_item.axis_b;
        r1_c   <= i_item.axis_c;
        r1_bx  <= i_item.base_x;
        r1_by  <= i_item.base_y;
        r1_bz  <= i_item.base_z;
        r1_len <= i_item.span_length;
        r1_ll  <= i_item.span_length * i_item.span_length;
        r1_q   <= $unsigned(w_aa) + $unsigned(w_bb);
    end

    // ---------------------------------------------------------------
    // Stage 2: all cross products in parallel
    // ---------------------------------------------------------------
    logic                r2_v;
    tvht_pkg::t_ctl      r2_ctl;
    logic signed [32:0]  r2_dx, r2_dy;
    logic signed [48:0]  r2_dya, r2_dxb, r2_dxa, r2_dyb;
    logic [62:0]         r2_lqh, r2_lql, r2_hq;
    logic signed [47:0]  r2_bl, r2_al;
    logic signed [47:0]  r2_dm0, r2_dm1, r2_dm2;
    logic signed [47:0]  r2_db0, r2_db1, r2_db2;
    logic signed [47:0]  r2_da0, r2_da1, r2_da2;
    logic [61:0]         r2_ll;
    logic signed [31:0]  w_len_s;

    assign w_len_s = $signed({1'b0, r1_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        r2_ctl <= r1_ctl;
        r2_dx  <= r1_dx;
        r2_dy  <= r1_dy;
        r2_dya <= r1_dy * r1_a;
        r2_dxb <= r1_dx * r1_b;
        r2_dxa <= r1_dx * r1_a;
        r2_dyb <= r1_dy * r1_b;
        // L^2 * q split across the upper and lower halves of L^2
        r2_lqh <= r1_ll[61:31] * r1_q;
        r2_lql <= r1_ll[30:0] * r1_q;
        r2_hq  <= r1_len * r1_q;
        r2_bl  <= r1_b * w_len_s;
        r2_al  <= r1_a * w_len_s;
        r2_dm0 <= r_motion_x * r1_a;
        r2_dm1 <= r_motion_y * r1_b;
        r2_dm2 <= r_motion_z * r1_c;
        r2_db0 <= r1_bx * r1_a;
        r2_db1 <= r1_by * r1_b;
        r2_db2 <= r1_bz * r1_c;
        r2_da0 <= r_actor_x * r1_a;
        r2_da1 <= r_actor_y * r1_b;
        r2_da2 <= r_actor_z * r1_c;
        r2_ll  <= r1_ll;
    end

    // ---------------------------------------------------------------
    // Stage 3: sums and endpoint offsets
    // ---------------------------------------------------------------
    logic signed [47:0]  w_dx15, w_dy15;
    logic                r3_v;
    tvht_pkg::t_ctl      r3_ctl;
    logic signed [49:0]  r3_m, r3_cr;
    logic signed [49:0]  r3_ux0, r3_ux2, r3_uy0, r3_uy2;
    logic signed [49:0]  r3_dm, r3_db, r3_da;
    logic [93:0]         r3_lq;
    logic [62:0]         r3_hq;
    logic [61:0]         r3_ll;

    assign w_dx15 = $signed({r2_dx, 15'b0});
    assign w_dy15 = $signed({r2_dy, 15'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        r3_ctl <= r2_ctl;
        r3_m   <= 50'(r2_dya) - 50'(r2_dxb);
        r3_cr  <= 50'(r2_dxa) + 50'(r2_dyb);
        // far end offsets, then near end offsets
        r3_ux0 <= 50'(w_dx15) - 50'(r2_bl);
        r3_uy0 <= 50'(w_dy15) + 50'(r2_al);
        r3_ux2 <= 50'(w_dx15) + 50'(r2_bl);
        r3_uy2 <= 50'(w_dy15) - 50'(r2_al);
        r3_dm  <= 50'(r2_dm0) + 50'(r2_dm1) + 50'(r2_dm2);
        r3_db  <= 50'(r2_db0) + 50'(r2_db1) + 50'(r2_db2);
        r3_da  <= 50'(r2_da0) + 50'(r2_da1) + 50'(r2_da2);
        r3_lq  <= (94'(r2_lqh) << 31) + 94'(r2_lql);
        r3_hq  <= r2_hq;
        r3_ll  <= r2_ll;
    end

    // ---------------------------------------------------------------
    // Stage 4: region of the clamped fraction, plane side, magnitudes
    // ---------------------------------------------------------------
    logic [63:0]         w_mm;
    logic [1:0]          n4_region;
    logic                r4_v;
    tvht_pkg::t_ctl      r4_ctl;
    logic [1:0]          r4_region;
    logic                r4_pl;
    logic [tvht_pkg::MAG_W-1:0] r4_cm, r4_ax0, r4_ax2, r4_ay0, r4_ay2;
    logic [93:0]         r4_lq;
    logic [61:0]         r4_ll;

    assign w_mm = {f_mag(r3_m), 15'b0};

    // A short segment pins the fraction to 0; otherwise compare |m| against
    // L*q to decide between the interior and the clamped ends.
    always_comb begin
        if (r3_lq > tvht_pkg::LQ_LIM) begin
            if (w_mm < 64'(r3_hq))  n4_region = tvht_pkg::REGION_IN;
            else if (r3_m < 0)      n4_region = tvht_pkg::REGION_FAR;
            else                    n4_region = tvht_pkg::REGION_NEAR;
        end else begin
            n4_region = tvht_pkg::REGION_FAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        r4_ctl    <= r3_ctl;
        r4_region <= n4_region;
        r4_pl     <= ((r3_db < r3_dm) == (r3_da < r3_db));
        r4_cm     <= f_mag(r3_cr);
        r4_ax0    <= f_mag(r3_ux0);
        r4_ax2    <= f_mag(r3_ux2);
        r4_ay0    <= f_mag(r3_uy0);
        r4_ay2    <= f_mag(r3_uy2);
        r4_lq     <= r3_lq;
        r4_ll     <= r3_ll;
    end

    // ---------------------------------------------------------------
    // Stages 5-6: squares. Interior uses sq1 alone (perpendicular term);
    // clamped ends use sq1 + sq2 (distance to the end point).
    // ---------------------------------------------------------------
    logic [tvht_pkg::MAG_W-1:0] w_sq1_in, w_sq2_in;
    logic [tvht_pkg::SQ_W-1:0]  w_sq1, w_sq2;

    always_comb begin
        case (r4_region)
            tvht_pkg::REGION_IN:   w_sq1_in = r4_cm;
            tvht_pkg::REGION_FAR:  w_sq1_in = r4_ax0;
            default:               w_sq1_in = r4_ax2;
        endcase
        w_sq2_in = (r4_region == tvht_pkg::REGION_FAR) ? r4_ay0 : r4_ay2;
    end

    tvht_sq u_sq1 (.i_clk(i_clk), .i_x(w_sq1_in), .o_sq(w_sq1));
    tvht_sq u_sq2 (.i_clk(i_clk), .i_x(w_sq2_in), .o_sq(w_sq2));

    logic           r5_v, r6_v;
    tvht_pkg::t_ctl r5_ctl, r6_ctl;
    logic [1:0]     r5_region, r6_region;
    logic           r5_pl, r6_pl;
    logic [93:0]    r5_lq, r6_lq;
    logic [61:0]    r5_ll, r6_ll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_ctl    <= r4_ctl;
        r5_region <= r4_region;
        r5_pl     <= r4_pl;
        r5_lq     <= r4_lq;
        r5_ll     <= r4_ll;
        r6_ctl    <= r5_ctl;
        r6_region <= r5_region;
        r6_pl     <= r5_pl;
        r6_lq     <= r5_lq;
        r6_ll     <= r5_ll;
    end

    // ---------------------------------------------------------------
    // Stage 7: interior radius compare, end-point distance sum
    // ---------------------------------------------------------------
    logic                    r7_v;
    tvht_pkg::t_ctl          r7_ctl;
    logic [1:0]              r7_region;
    logic                    r7_pl;
    logic                    r7_c1;
    logic [tvht_pkg::SQ_W:0] r7_d2;
    logic [61:0]             r7_ll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else          r7_v <= r6_v;
    end

    always_ff @(posedge i_clk) begin
        r7_ctl    <= r6_ctl;
        r7_region <= r6_region;
        r7_pl     <= r6_pl;
        r7_c1     <= {w_sq1, 2'b00} < (tvht_pkg::SQ_W + 2)'(r6_lq);
        r7_d2     <= (tvht_pkg::SQ_W + 1)'(w_sq1) + (tvht_pkg::SQ_W + 1)'(w_sq2);
        r7_ll     <= r6_ll;
    end

    // ---------------------------------------------------------------
    // Stage 8: final decision, result register
    // ---------------------------------------------------------------
    logic              w_in, w_c2, w_fire;
    logic              r8_v;
    tvht_pkg::t_result r8_res;

    assign w_in = (r7_region == tvht_pkg::REGION_IN);
    assign w_c2 = r7_d2 < (tvht_pkg::SQ_W + 1)'({r7_ll, 28'b0});

    always_comb begin
        if (r7_ctl.plane) w_fire = w_in && r7_pl;
        else if (w_in)    w_fire = r7_c1;
        else              w_fire = w_c2;
        w_fire = w_fire && r7_ctl.go && r7_ctl.hgt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else          r8_v <= r7_v;
    end

    always_ff @(posedge i_clk) begin
        r8_res.fire  <= w_fire;
        r8_res.gated <= r7_ctl.blk;
    end

    assign o_done   = r8_v;
    assign o_result = r8_res;

endmodule

### rtl/core/tvht_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the trigger volume hit test, bound to the top level.
module tvht_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input tvht_pkg::t_result o_result,
    input logic              pready
);

    // The pipeline never holds off a command.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    // Every accepted transaction yields its result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_done) else $error("result missing");

    // No result without an earlier command.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 8)) else $error("unexpected result");

    // A gated record never fires.
    a_gated_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.gated) |-> !o_result.fire)
        else $error("gated record fired");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");

endmodule

bind trigger_volume_hit_test_unit tvht_checker u_tvht_checker (.*);
